### design/s20_pkg.sv
package s20_pkg;

	// Round count and the pipeline depth that follows from it
	localparam int ROUND_COUNT   = 20;
	localparam int DOUBLE_ROUNDS = (ROUND_COUNT + 1) / 2;
	localparam int STEPS_PER_DR  = 4;
	localparam int STAGES        = DOUBLE_ROUNDS * STEPS_PER_DR;
	localparam int WORDS         = 16;

	typedef logic [31:0] word_t;
	typedef word_t [WORDS-1:0] state_t;
	typedef logic [3:0] widx_t;

	// Each stage does half of a quarter round on all four quarters at once
	typedef enum logic [1:0] {
		STEP_COL_BC = 2'd0,
		STEP_COL_DA = 2'd1,
		STEP_ROW_BC = 2'd2,
		STEP_ROW_DA = 2'd3
	} step_t;

	// Word positions of a, b, c, d for each quarter round
	localparam widx_t COL_IDX [4][4] = '{
		'{4'd0,  4'd4,  4'd8,  4'd12},
		'{4'd5,  4'd9,  4'd13, 4'd1},
		'{4'd10, 4'd14, 4'd2,  4'd6},
		'{4'd15, 4'd3,  4'd7,  4'd11}
	};
	localparam widx_t ROW_IDX [4][4] = '{
		'{4'd0,  4'd1,  4'd2,  4'd3},
		'{4'd5,  4'd6,  4'd7,  4'd4},
		'{4'd10, 4'd11, 4'd8,  4'd9},
		'{4'd15, 4'd12, 4'd13, 4'd14}
	};

	localparam int ROLE_A = 0;
	localparam int ROLE_B = 1;
	localparam int ROLE_C = 2;
	localparam int ROLE_D = 3;

	function automatic word_t rotl(input word_t v, input logic [4:0] s);
		rotl = (v << s) | (v >> (6'd32 - {1'b0, s}));
	endfunction

endpackage

### design/s20_in_if.sv
interface s20_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] in_words_0_1;
	logic [63:0] in_words_2_3;
	logic [63:0] in_words_4_5;
	logic [63:0] in_words_6_7;
	logic [63:0] in_words_8_9;
	logic [63:0] in_words_10_11;
	logic [63:0] in_words_12_13;
	logic [63:0] in_words_14_15;

	modport source (
		output valid, in_words_0_1, in_words_2_3, in_words_4_5, in_words_6_7,
		       in_words_8_9, in_words_10_11, in_words_12_13, in_words_14_15,
		input  ready
	);
	modport sink (
		input  valid, in_words_0_1, in_words_2_3, in_words_4_5, in_words_6_7,
		       in_words_8_9, in_words_10_11, in_words_12_13, in_words_14_15,
		output ready
	);
endinterface

### design/s20_out_if.sv
interface s20_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] out_words_0_1;
	logic [63:0] out_words_2_3;
	logic [63:0] out_words_4_5;
	logic [63:0] out_words_6_7;
	logic [63:0] out_words_8_9;
	logic [63:0] out_words_10_11;
	logic [63:0] out_words_12_13;
	logic [63:0] out_words_14_15;

	modport source (
		output valid, out_words_0_1, out_words_2_3, out_words_4_5, out_words_6_7,
		       out_words_8_9, out_words_10_11, out_words_12_13, out_words_14_15,
		input  ready
	);
	modport sink (
		input  valid, out_words_0_1, out_words_2_3, out_words_4_5, out_words_6_7,
		       out_words_8_9, out_words_10_11, out_words_12_13, out_words_14_15,
		output ready
	);
endinterface

### design/s20_round_stage.sv
module s20_round_stage (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  s20_pkg::step_t  step,
	input  logic            vld_in,
	input  s20_pkg::state_t st_in,
	input  s20_pkg::state_t orig_in,
	output logic            vld_s1,
	output s20_pkg::state_t st_s1,
	output s20_pkg::state_t orig_s1
);
	import s20_pkg::*;

	state_t st_nxt;

	// Two dependent add-rotate-xor steps on each of the four quarters
	always_comb begin
		widx_t ia;
		widx_t ib;
		widx_t ic;
		widx_t id;
		st_nxt = st_in;
		for (int q = 0; q < 4; q++) begin
			if (step == STEP_ROW_BC || step == STEP_ROW_DA) begin
				ia = ROW_IDX[q][ROLE_A];
				ib = ROW_IDX[q][ROLE_B];
				ic = ROW_IDX[q][ROLE_C];
				id = ROW_IDX[q][ROLE_D];
			end else begin
				ia = COL_IDX[q][ROLE_A];
				ib = COL_IDX[q][ROLE_B];
				ic = COL_IDX[q][ROLE_C];
				id = COL_IDX[q][ROLE_D];
			end
			case (step)
				STEP_COL_BC, STEP_ROW_BC: begin
					st_nxt[ib] = st_nxt[ib] ^ rotl(st_nxt[ia] + st_nxt[id], 5'd7);
					st_nxt[ic] = st_nxt[ic] ^ rotl(st_nxt[ib] + st_nxt[ia], 5'd9);
				end
				STEP_COL_DA, STEP_ROW_DA: begin
					st_nxt[id] = st_nxt[id] ^ rotl(st_nxt[ic] + st_nxt[ib], 5'd13);
					st_nxt[ia] = st_nxt[ia] ^ rotl(st_nxt[id] + st_nxt[ic], 5'd18);
				end
				default: begin
					st_nxt[ia] = st_nxt[ia];
				end
			endcase
		end
	end

	// Valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
		end
	end

	// Payload, no reset
	always_ff @(posedge clk) begin
		if (en && vld_in) begin
			st_s1   <= st_nxt;
			orig_s1 <= orig_in;
		end
	end

	// A held stage keeps its item
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_s1) && (!vld_s1 || ($stable(st_s1) && $stable(orig_s1))))
		else $error("stage changed while pipeline held");

endmodule

### design/s20_out_buf.sv
module s20_out_buf (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            vld_in,
	input  s20_pkg::state_t st_in,
	input  s20_pkg::state_t orig_in,
	output logic            en,
	output logic            out_vld,
	output s20_pkg::state_t out_st,
	input  logic            out_rdy
);
	import s20_pkg::*;

	state_t sum;
	state_t out_q;
	state_t skid_q;
	logic   out_vld_q;
	logic   skid_vld_q;
	logic   take;

	// Feed-forward add of the original words
	always_comb begin
		for (int k = 0; k < WORDS; k++) begin
			sum[k] = st_in[k] + orig_in[k];
		end
	end

	assign take    = out_vld_q && out_rdy;
	assign en      = !skid_vld_q;
	assign out_vld = out_vld_q;
	assign out_st  = out_q;

	// Output register with one skid entry behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (take) begin
				skid_vld_q <= 1'b0;
			end
		end else if (vld_in) begin
			if (out_vld_q && !take) begin
				skid_vld_q <= 1'b1;
			end else begin
				out_vld_q <= 1'b1;
			end
		end else if (take) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (take) begin
				out_q <= skid_q;
			end
		end else if (vld_in) begin
			if (out_vld_q && !take) begin
				skid_q <= sum;
			end else begin
				out_q <= sum;
			end
		end
	end

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid entry held with empty output register");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_vld_q) |-> $past(out_vld_q && !out_rdy && vld_in))
		else $error("skid filled without a stalled result");

	a_skid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q && !take |=> skid_vld_q && $stable(skid_q))
		else $error("skid entry lost");

endmodule

### design/salsa20_block_function.sv
// Salsa20/20 block function, fully pipelined.
//
// block  (sink):   one 512-bit input block per item, word 2k in the low half
//                  of in_words_<2k>_<2k+1>, word 2k+1 in the high half.
// result (source): the 512-bit result block, packed the same way.
//
// Each double round takes four register stages (column round in two halves,
// row round in two halves, two add-rotate-xor steps per quarter round each),
// so ten double rounds give 40 stages. The final word-wise add sits in the
// output register. A new item can be accepted every cycle while the skid
// entry is empty.
//
// block.ready is driven from a register: when result stalls, the item in
// the output register holds and one more item lands in a skid entry, after
// which the whole pipeline holds. Nothing is dropped or repeated.
// Reset clears all valid bits; data registers are not reset.
module salsa20_block_function (
	input  logic      clk,
	input  logic      arst_n,
	s20_in_if.sink    block,
	s20_out_if.source result
);
	import s20_pkg::*;

	state_t stg_st   [STAGES+1];
	state_t stg_orig [STAGES+1];
	logic   stg_vld  [STAGES+1];
	state_t res_st;
	logic   en;

	// Unpack input words, word 0 in the low bits
	assign stg_st[0] = {
		block.in_words_14_15, block.in_words_12_13,
		block.in_words_10_11, block.in_words_8_9,
		block.in_words_6_7,   block.in_words_4_5,
		block.in_words_2_3,   block.in_words_0_1
	};

	assign stg_orig[0] = stg_st[0];
	assign stg_vld[0]  = block.valid;
	assign block.ready = en;

	// Round pipeline
	for (genvar g = 0; g < STAGES; g++) begin : g_stage
		s20_round_stage u_stage (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.step    (step_t'(2'(g % STEPS_PER_DR))),
			.vld_in  (stg_vld[g]),
			.st_in   (stg_st[g]),
			.orig_in (stg_orig[g]),
			.vld_s1  (stg_vld[g+1]),
			.st_s1   (stg_st[g+1]),
			.orig_s1 (stg_orig[g+1])
		);
	end

	// Feed-forward add and output buffering
	s20_out_buf u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_in  (stg_vld[STAGES]),
		.st_in   (stg_st[STAGES]),
		.orig_in (stg_orig[STAGES]),
		.en      (en),
		.out_vld (result.valid),
		.out_st  (res_st),
		.out_rdy (result.ready)
	);

	// Pack result words
	assign result.out_words_0_1   = {res_st[1],  res_st[0]};
	assign result.out_words_2_3   = {res_st[3],  res_st[2]};
	assign result.out_words_4_5   = {res_st[5],  res_st[4]};
	assign result.out_words_6_7   = {res_st[7],  res_st[6]};
	assign result.out_words_8_9   = {res_st[9],  res_st[8]};
	assign result.out_words_10_11 = {res_st[11], res_st[10]};
	assign result.out_words_12_13 = {res_st[13], res_st[12]};
	assign result.out_words_14_15 = {res_st[15], res_st[14]};

endmodule

### dv/tb_salsa20_block_function.sv
module tb_salsa20_block_function;
	timeunit 1ns;
	timeprecision 1ps;

	import s20_pkg::*;

	localparam int PERIOD_NS  = 10;
	localparam int RESET_CYC  = 10;
	localparam int LATENCY    = 41;
	localparam int IDLE_LIMIT = 5000;
	localparam int PHASE_ITEMS = 200;

	logic clk = 1'b0;
	logic arst_n;

	s20_in_if  blk_if ();
	s20_out_if res_if ();

	salsa20_block_function dut (
		.clk    (clk),
		.arst_n (arst_n),
		.block  (blk_if.sink),
		.result (res_if.source)
	);

	// hash results still owed by the block, oldest first
	state_t expected_hashes [$];
	int     mismatch_count = 0;
	int     gap_pct        = 0;
	int     stall_pct      = 0;
	int     idle_cycles    = 0;

	always #(PERIOD_NS / 2) clk = ~clk;

	// ---------------- predictor ----------------

	function automatic word_t rol32(input word_t v, input int s);
		logic [63:0] dbl;
		dbl = {v, v} << s;
		return dbl[63:32];
	endfunction

	// one quarter round, returns {a, b, c, d}
	function automatic logic [127:0] quarter_round(input word_t a, b, c, d);
		b = b ^ rol32(a + d, 7);
		c = c ^ rol32(b + a, 9);
		d = d ^ rol32(c + b, 13);
		a = a ^ rol32(d + c, 18);
		return {a, b, c, d};
	endfunction

	function automatic state_t salsa20_hash(input state_t src);
		word_t  w [WORDS];
		state_t sum;
		for (int k = 0; k < WORDS; k++)
			w[k] = src[k];
		// odd round counts still run whole double rounds
		for (int dr = 0; dr < (ROUND_COUNT + 1) / 2; dr++) begin
			{w[0],  w[4],  w[8],  w[12]} = quarter_round(w[0],  w[4],  w[8],  w[12]);
			{w[5],  w[9],  w[13], w[1]}  = quarter_round(w[5],  w[9],  w[13], w[1]);
			{w[10], w[14], w[2],  w[6]}  = quarter_round(w[10], w[14], w[2],  w[6]);
			{w[15], w[3],  w[7],  w[11]} = quarter_round(w[15], w[3],  w[7],  w[11]);
			{w[0],  w[1],  w[2],  w[3]}  = quarter_round(w[0],  w[1],  w[2],  w[3]);
			{w[5],  w[6],  w[7],  w[4]}  = quarter_round(w[5],  w[6],  w[7],  w[4]);
			{w[10], w[11], w[8],  w[9]}  = quarter_round(w[10], w[11], w[8],  w[9]);
			{w[15], w[12], w[13], w[14]} = quarter_round(w[15], w[12], w[13], w[14]);
		end
		for (int k = 0; k < WORDS; k++)
			sum[k] = w[k] + src[k];
		return sum;
	endfunction

	// ---------------- block sender ----------------

	// send one block; returns at the edge that accepted it, valid left high
	task automatic send_block(input state_t b);
		state_t hash;
		hash = salsa20_hash(b);
		while ($urandom_range(99) < gap_pct) begin
			blk_if.valid <= 1'b0;
			@(posedge clk);
		end
		blk_if.valid          <= 1'b1;
		blk_if.in_words_0_1   <= {b[1],  b[0]};
		blk_if.in_words_2_3   <= {b[3],  b[2]};
		blk_if.in_words_4_5   <= {b[5],  b[4]};
		blk_if.in_words_6_7   <= {b[7],  b[6]};
		blk_if.in_words_8_9   <= {b[9],  b[8]};
		blk_if.in_words_10_11 <= {b[11], b[10]};
		blk_if.in_words_12_13 <= {b[13], b[12]};
		blk_if.in_words_14_15 <= {b[15], b[14]};
		do
			@(posedge clk);
		while (!blk_if.ready);
		expected_hashes.push_back(hash);
	endtask

	// lower valid and wait until every owed hash has come out
	task automatic drain_results();
		blk_if.valid <= 1'b0;
		while (expected_hashes.size() != 0)
			@(posedge clk);
	endtask

	// words biased toward carry and rotate corner values
	function automatic state_t random_block();
		state_t b;
		for (int k = 0; k < WORDS; k++) begin
			case ($urandom_range(7))
				0: b[k] = '0;
				1: b[k] = '1;
				2: b[k] = word_t'(1) << $urandom_range(31);
				default: b[k] = $urandom();
			endcase
		end
		return b;
	endfunction

	task automatic send_random_blocks(input int count);
		for (int i = 0; i < count; i++)
			send_block(random_block());
	endtask

	// ---------------- result receiver ----------------

	always @(posedge clk)
		res_if.ready <= ($urandom_range(99) >= stall_pct);

	// compare each accepted result with the oldest owed hash
	always @(posedge clk) begin
		state_t got;
		state_t want;
		if (arst_n && res_if.valid && res_if.ready) begin
			{got[1],  got[0]}  = res_if.out_words_0_1;
			{got[3],  got[2]}  = res_if.out_words_2_3;
			{got[5],  got[4]}  = res_if.out_words_4_5;
			{got[7],  got[6]}  = res_if.out_words_6_7;
			{got[9],  got[8]}  = res_if.out_words_8_9;
			{got[11], got[10]} = res_if.out_words_10_11;
			{got[13], got[12]} = res_if.out_words_12_13;
			{got[15], got[14]} = res_if.out_words_14_15;
			if (expected_hashes.size() == 0) begin
				$error("unexpected result item: %h", got);
				mismatch_count++;
			end else begin
				want = expected_hashes.pop_front();
				for (int k = 0; k < WORDS / 2; k++) begin
					if ({got[2*k+1], got[2*k]} !== {want[2*k+1], want[2*k]}) begin
						$error("out_words_%0d_%0d: expected %h, got %h", 2*k, 2*k+1,
							{want[2*k+1], want[2*k]}, {got[2*k+1], got[2*k]});
						mismatch_count++;
					end
				end
			end
		end
	end

	// watchdog: cycles with no item moving on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((blk_if.valid && blk_if.ready) || (res_if.valid && res_if.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("** salsa20_block_function: FAILED **");
				$finish;
			end
		end
	end

	// ---------------- tests ----------------

	task automatic test_reset();
		arst_n                <= 1'b0;
		blk_if.valid          <= 1'b0;
		blk_if.in_words_0_1   <= '0;
		blk_if.in_words_2_3   <= '0;
		blk_if.in_words_4_5   <= '0;
		blk_if.in_words_6_7   <= '0;
		blk_if.in_words_8_9   <= '0;
		blk_if.in_words_10_11 <= '0;
		blk_if.in_words_12_13 <= '0;
		blk_if.in_words_14_15 <= '0;
		repeat (RESET_CYC) @(posedge clk);
		arst_n <= 1'b1;
	endtask

	// whole-block extremes and alternating patterns
	task automatic test_corner_blocks();
		state_t b;
		b = '0;
		send_block(b);
		b = '1;
		send_block(b);
		for (int k = 0; k < WORDS; k++)
			b[k] = 32'h5555_5555;
		send_block(b);
		for (int k = 0; k < WORDS; k++)
			b[k] = 32'hAAAA_AAAA;
		send_block(b);
	endtask

	// one word set, the rest clear: each position of each quarter round
	task automatic test_single_word_patterns();
		state_t b;
		for (int k = 0; k < WORDS; k++) begin
			b    = '0;
			b[k] = '1;
			send_block(b);
		end
		b    = '0;
		b[0] = 32'h0000_0001;
		send_block(b);
		b     = '0;
		b[15] = 32'h8000_0000;
		send_block(b);
	endtask

	task automatic test_back_to_back();
		gap_pct   = 0;
		stall_pct = 0;
		send_random_blocks(PHASE_ITEMS);
	endtask

	task automatic test_sender_gaps();
		gap_pct   = 61;
		stall_pct = 0;
		send_random_blocks(PHASE_ITEMS);
	endtask

	task automatic test_receiver_stalls();
		gap_pct   = 0;
		stall_pct = 61;
		send_random_blocks(PHASE_ITEMS);
	endtask

	// both sides idling, with a full drain partway through
	task automatic test_mixed_idling();
		gap_pct   = 30;
		stall_pct = 30;
		send_random_blocks(PHASE_ITEMS / 2);
		drain_results();
		send_random_blocks(PHASE_ITEMS - PHASE_ITEMS / 2);
	endtask

	initial begin
		test_reset();
		test_corner_blocks();
		test_single_word_patterns();
		test_back_to_back();
		test_sender_gaps();
		test_receiver_stalls();
		test_mixed_idling();
		drain_results();
		repeat (LATENCY + 20) @(posedge clk);
		if (mismatch_count == 0 && expected_hashes.size() == 0) begin
			$display("** salsa20_block_function: PASSED **");
		end else begin
			if (expected_hashes.size() != 0)
				$error("%0d expected results never arrived", expected_hashes.size());
			$display("** salsa20_block_function: FAILED **");
		end
		$finish;
	end

endmodule
